// ===== design/pdc_pkg.sv =====
package pdc_pkg;

  // Field widths fixed by the interface
  localparam int VAL_W     = 16;           // setpoint / measurement
  localparam int GAIN_W    = 24;           // gain registers
  localparam int DUTY_W    = 7;            // duty limits and result
  localparam int ERR_W     = VAL_W + 1;    // error and measurement delta
  localparam int PROD_W    = GAIN_W + 1 + ERR_W;  // signed gain x error product
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = GAIN_W;

  localparam int FRACTION_BITS_DEF = 16;

  // Angle wrap limits, degrees
  localparam int ANGLE_HALF = 180;
  localparam int ANGLE_FULL = 360;

  // Register reset values
  localparam logic [GAIN_W-1:0] KP_RST    = 24'd458752;
  localparam logic [GAIN_W-1:0] KI_RST    = 24'd2731;
  localparam logic [GAIN_W-1:0] KD_RST    = 24'd157286;
  localparam logic [DUTY_W-1:0] FLOOR_RST = 7'd2;
  localparam logic [DUTY_W-1:0] CEIL_RST  = 7'd98;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP    = 3'd0,
    REG_KI    = 3'd1,
    REG_KD    = 3'd2,
    REG_FLOOR = 3'd3,
    REG_CEIL  = 3'd4,
    REG_WRAP  = 3'd5,
    REG_RISE  = 3'd6
  } cfg_idx_t;

  // Live configuration handed to the datapath stages
  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [DUTY_W-1:0] duty_floor;
    logic [DUTY_W-1:0] duty_ceiling;
    logic              angle_wrap;
    logic              deriv_rise;
  } cfg_t;

endpackage

// ===== design/pdc_intf.sv =====
// Input channel: one setpoint/measurement pair per request
interface pdc_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [pdc_pkg::VAL_W-1:0]  target_value;
  logic signed [pdc_pkg::VAL_W-1:0]  measured_value;

  modport source (output valid, output target_value, output measured_value, input ready);
  modport sink   (input valid, input target_value, input measured_value, output ready);
endinterface

// Result channel: one duty value per request
interface pdc_out_if;
  logic                        valid;
  logic                        ready;
  logic [pdc_pkg::DUTY_W-1:0]  duty_percent;

  modport source (output valid, output duty_percent, input ready);
  modport sink   (input valid, input duty_percent, output ready);
endinterface

// Register write channel
interface pdc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pdc_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [pdc_pkg::CFG_DAT_W-1:0]  wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== design/pid_duty_controller_core.sv =====
// PID duty controller.
// in_ch carries one request per control tick: target_value and measured_value,
// signed 16-bit in the same units. out_ch returns one duty_percent (0..127,
// normally within the duty limits) for every request, in order.
// cfg_ch writes the gain, limit and mode registers by index; it is always
// ready, and writes take effect on the next request. Write only while idle.
// A request accepted on in_ch passes through the input register, the product
// register and the result register before its result shows on out_ch.
// Throughput: one request per cycle while out_ch is ready. The integral loop
// closes through one add-and-clamp stage in the result stage, which sets the
// cycle time together with the 25x17 multiplies of the product stage.
// Each stage holds its request while the stage after it is not ready, so a stall
// on out_ch fills up to three requests before in_ch.ready drops.
// Reset (rst_n low, synchronous) empties the pipeline, clears the integral
// and the stored previous measurement, and restores register defaults.
module pid_duty_controller_core #(
  parameter int FRACTION_BITS = pdc_pkg::FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pdc_in_if.sink    in_ch,
  pdc_out_if.source out_ch,
  pdc_cfg_if.sink   cfg_ch
);
  import pdc_pkg::*;

  cfg_t                    cfg_r;
  logic                    in_valid_r;
  logic signed [VAL_W-1:0] target_r, meas_r, prev_meas_r, last_meas_r;
  logic                    in_fire;
  logic                    prod_ready, prod_valid, acc_ready;
  logic signed [PROD_W-1:0] p_term, di_term, d_term;

  // Register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp           <= KP_RST;
      cfg_r.ki           <= KI_RST;
      cfg_r.kd           <= KD_RST;
      cfg_r.duty_floor   <= FLOOR_RST;
      cfg_r.duty_ceiling <= CEIL_RST;
      cfg_r.angle_wrap   <= 1'b0;
      cfg_r.deriv_rise   <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.reg_index))
        REG_KP:    cfg_r.kp           <= cfg_ch.wdata[GAIN_W-1:0];
        REG_KI:    cfg_r.ki           <= cfg_ch.wdata[GAIN_W-1:0];
        REG_KD:    cfg_r.kd           <= cfg_ch.wdata[GAIN_W-1:0];
        REG_FLOOR: cfg_r.duty_floor   <= cfg_ch.wdata[DUTY_W-1:0];
        REG_CEIL:  cfg_r.duty_ceiling <= cfg_ch.wdata[DUTY_W-1:0];
        REG_WRAP:  cfg_r.angle_wrap   <= cfg_ch.wdata[0];
        REG_RISE:  cfg_r.deriv_rise   <= cfg_ch.wdata[0];
        default:   cfg_r              <= cfg_r;
      endcase
    end
  end

  // Input register; the previous measurement is captured at accept time
  assign in_ch.ready = !in_valid_r || prod_ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      last_meas_r <= '0;
    end else if (in_fire) begin
      in_valid_r  <= 1'b1;
      last_meas_r <= in_ch.measured_value;
    end else if (prod_ready) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      target_r    <= in_ch.target_value;
      meas_r      <= in_ch.measured_value;
      prev_meas_r <= last_meas_r;
    end
  end

  // Error, wrap and gain products
  pdc_prod u_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .up_valid  (in_valid_r),
    .up_ready  (prod_ready),
    .target    (target_r),
    .meas      (meas_r),
    .prev_meas (prev_meas_r),
    .dn_valid  (prod_valid),
    .dn_ready  (acc_ready),
    .p_term    (p_term),
    .di_term   (di_term),
    .d_term    (d_term)
  );

  // Integral update, floor and clamps
  pdc_accum #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (prod_valid),
    .up_ready (acc_ready),
    .p_term   (p_term),
    .di_term  (di_term),
    .d_term   (d_term),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .duty     (out_ch.duty_percent)
  );

`ifndef SYNTHESIS
  // Stored measurement follows every accepted request
  a_last_meas: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> last_meas_r == $past(in_ch.measured_value))
    else $error("previous measurement not updated on accept");

  // A stalled input register keeps its request
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !prod_ready |=> in_valid_r && $stable(target_r) && $stable(meas_r))
    else $error("input register lost a stalled request");

  // A new result only appears after the product stage hands one over
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(prod_valid && acc_ready))
    else $error("result raised without a request from the product stage");
`endif

endmodule

// ===== design/pdc_prod.sv =====
module pdc_prod (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pdc_pkg::cfg_t                        cfg,
  input  logic                                 up_valid,
  output logic                                 up_ready,
  input  logic signed [pdc_pkg::VAL_W-1:0]     target,
  input  logic signed [pdc_pkg::VAL_W-1:0]     meas,
  input  logic signed [pdc_pkg::VAL_W-1:0]     prev_meas,
  output logic                                 dn_valid,
  input  logic                                 dn_ready,
  output logic signed [pdc_pkg::PROD_W-1:0]    p_term,
  output logic signed [pdc_pkg::PROD_W-1:0]    di_term,
  output logic signed [pdc_pkg::PROD_W-1:0]    d_term
);
  import pdc_pkg::*;

  localparam logic signed [ERR_W-1:0] WRAP_HI   = ERR_W'(ANGLE_HALF);
  localparam logic signed [ERR_W-1:0] WRAP_LO   = -ERR_W'(ANGLE_HALF);
  localparam logic signed [ERR_W-1:0] WRAP_FULL = ERR_W'(ANGLE_FULL);

  logic signed [ERR_W-1:0]  err_raw;
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  delta;
  logic signed [GAIN_W:0]   kp_s, ki_s, kd_s;
  logic signed [PROD_W-1:0] p_nxt, di_nxt, d_nxt;
  logic signed [PROD_W-1:0] p_r, di_r, d_r;
  logic                     valid_r;
  logic                     adv;

  // Error with optional single wrap by a full turn
  always_comb begin
    err_raw = {target[VAL_W-1], target} - {meas[VAL_W-1], meas};
    err     = err_raw;
    if (cfg.angle_wrap) begin
      if (err_raw > WRAP_HI) begin
        err = err_raw - WRAP_FULL;
      end else if (err_raw < WRAP_LO) begin
        err = err_raw + WRAP_FULL;
      end
    end
  end

  // Derivative on the measurement, sign selectable
  assign delta = cfg.deriv_rise
               ? ({meas[VAL_W-1], meas} - {prev_meas[VAL_W-1], prev_meas})
               : ({prev_meas[VAL_W-1], prev_meas} - {meas[VAL_W-1], meas});

  // Three independent gain multiplies
  assign kp_s   = {1'b0, cfg.kp};
  assign ki_s   = {1'b0, cfg.ki};
  assign kd_s   = {1'b0, cfg.kd};
  assign p_nxt  = kp_s * err;
  assign di_nxt = ki_s * err;
  assign d_nxt  = kd_s * delta;

  assign up_ready = !valid_r || dn_ready;
  assign adv      = up_valid && up_ready;

  // Product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= 1'b1;
    end else if (dn_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r  <= p_nxt;
      di_r <= di_nxt;
      d_r  <= d_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign p_term   = p_r;
  assign di_term  = di_r;
  assign d_term   = d_r;

endmodule

// ===== design/pdc_accum.sv =====
module pdc_accum #(
  parameter int FRACTION_BITS = pdc_pkg::FRACTION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pdc_pkg::cfg_t                        cfg,
  input  logic                                 up_valid,
  output logic                                 up_ready,
  input  logic signed [pdc_pkg::PROD_W-1:0]    p_term,
  input  logic signed [pdc_pkg::PROD_W-1:0]    di_term,
  input  logic signed [pdc_pkg::PROD_W-1:0]    d_term,
  output logic                                 dn_valid,
  input  logic                                 dn_ready,
  output logic [pdc_pkg::DUTY_W-1:0]           duty
);
  import pdc_pkg::*;

  localparam int INT_W = DUTY_W + FRACTION_BITS;  // clamped integral, whole part <= 127
  localparam int ACC_W = PROD_W + 1;
  localparam int SUM_W = PROD_W + 2;

  logic [INT_W-1:0]        integral_r, integral_nxt;
  logic signed [ACC_W-1:0] acc, acc_clamped;
  logic signed [ACC_W-1:0] lim_hi, lim_lo;
  logic signed [SUM_W-1:0] total, ctl, ctl_clamped;
  logic signed [SUM_W-1:0] ceil_w, floor_w;
  logic [DUTY_W-1:0]       duty_r;
  logic                    valid_r;
  logic                    adv;

  // Integral step and full sum; the floor is an arithmetic shift
  assign acc   = ACC_W'(integral_r) + ACC_W'(di_term);
  assign total = SUM_W'(p_term) + SUM_W'(acc) + SUM_W'(d_term);
  assign ctl   = total >>> FRACTION_BITS;

  // Output clamp: ceiling first, then floor
  assign ceil_w  = SUM_W'(cfg.duty_ceiling);
  assign floor_w = SUM_W'(cfg.duty_floor);

  always_comb begin
    ctl_clamped = ctl;
    if (ctl_clamped > ceil_w) begin
      ctl_clamped = ceil_w;
    end
    if (ctl_clamped < floor_w) begin
      ctl_clamped = floor_w;
    end
  end

  // Integral clamp to the same limits, in fixed point
  assign lim_hi = ACC_W'({cfg.duty_ceiling, {FRACTION_BITS{1'b0}}});
  assign lim_lo = ACC_W'({cfg.duty_floor, {FRACTION_BITS{1'b0}}});

  always_comb begin
    acc_clamped = acc;
    if (acc_clamped > lim_hi) begin
      acc_clamped = lim_hi;
    end
    if (acc_clamped < lim_lo) begin
      acc_clamped = lim_lo;
    end
    integral_nxt = acc_clamped[INT_W-1:0];
  end

  assign up_ready = !valid_r || dn_ready;
  assign adv      = up_valid && up_ready;

  // Integral state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      integral_r <= '0;
    end else if (adv) begin
      valid_r    <= 1'b1;
      integral_r <= integral_nxt;
    end else if (dn_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      duty_r <= ctl_clamped[DUTY_W-1:0];
    end
  end

  assign dn_valid = valid_r;
  assign duty     = duty_r;

endmodule
